// File: hdl/olc_pkg.sv
// Shared types, register codes and constants of the occupancy light controller.
`timescale 1ns / 1ps

package olc_pkg;

  // Defaults for the top-level parameters
  localparam longint unsigned SAMPLE_PERIOD_US_DEF = 64'd500000;
  localparam longint unsigned MANUAL_HOLD_US_DEF   = 64'd300000000;
  localparam longint unsigned VACANT_HOLD_US_DEF   = 64'd600000000;
  localparam int              TIME_WIDTH_DEF       = 48;

  // Fixed field widths
  localparam int NOW_WIDTH       = 48;
  localparam int LEVEL_WIDTH     = 7;
  localparam int LUX_WIDTH       = 16;
  localparam int TEMP_WIDTH      = 14;
  localparam int RGB_WIDTH       = 24;
  localparam int CAP_WIDTH       = 5;
  localparam int DARK_WIDTH      = 8;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 24;

  // Command constants
  localparam logic [LEVEL_WIDTH-1:0] MAX_LEVEL        = 7'd100;
  localparam logic [LEVEL_WIDTH-1:0] NIGHT_MAIN_LEVEL = 7'd2;
  localparam logic [LEVEL_WIDTH-1:0] NIGHT_BACK_LEVEL = 7'd10;
  localparam logic [TEMP_WIDTH-1:0]  NIGHT_TEMP       = 14'd2700;
  localparam logic [RGB_WIDTH-1:0]   RED_RGB          = 24'hff0000;
  localparam logic [DARK_WIDTH-1:0]  DARK_MAX         = 8'hff;

  // Capability mask bits
  localparam int CAP_MAIN_COLOUR = 0;
  localparam int CAP_MAIN_TEMP   = 1;
  localparam int CAP_MAIN_LEVEL  = 2;
  localparam int CAP_BACK_COLOUR = 3;
  localparam int CAP_BACK_LEVEL  = 4;

  // Register reset values
  localparam logic [TEMP_WIDTH-1:0] MAIN_TEMP_RST  = 14'd4000;
  localparam logic [LUX_WIDTH-1:0]  LUX_THRESH_RST = 16'd150;
  localparam logic [DARK_WIDTH-1:0] DARK_LIMIT_RST = 8'd120;

  // Result buffer depth
  localparam int OUT_DEPTH     = 4;
  localparam int OUT_PTR_WIDTH = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_WIDTH = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_NIGHT_MODE       = 3'd0,
    REG_MAIN_TEMPERATURE = 3'd1,
    REG_BACK_COLOR       = 3'd2,
    REG_HAS_BACKLIGHT    = 3'd3,
    REG_CAPABILITY_MASK  = 3'd4,
    REG_LUX_THRESHOLD    = 3'd5,
    REG_DARK_COUNT_LIMIT = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic                   night_mode;
    logic [TEMP_WIDTH-1:0]  main_temperature;
    logic [RGB_WIDTH-1:0]   back_color;
    logic                   has_backlight;
    logic [CAP_WIDTH-1:0]   capability_mask;
    logic [LUX_WIDTH-1:0]   lux_threshold;
    logic [DARK_WIDTH-1:0]  dark_count_limit;
  } cfg_t;

  typedef struct packed {
    logic [NOW_WIDTH-1:0]   now_us;
    logic                   lamp_on;
    logic                   lamp_on_valid;
    logic [LEVEL_WIDTH-1:0] lamp_level;
    logic                   lamp_level_valid;
    logic                   presence;
    logic                   presence_valid;
    logic [LUX_WIDTH-1:0]   ambient_lux;
    logic                   ambient_valid;
  } in_t;

  typedef struct packed {
    logic                   main_on_cmd;
    logic                   back_on_cmd;
    logic [LEVEL_WIDTH-1:0] main_level_cmd;
    logic                   main_level_write;
    logic [TEMP_WIDTH-1:0]  main_temp_cmd;
    logic                   main_temp_write;
    logic                   main_red_write;
    logic [RGB_WIDTH-1:0]   back_color_cmd;
    logic                   back_color_write;
    logic [LEVEL_WIDTH-1:0] back_level_cmd;
    logic                   back_level_write;
  } out_t;

endpackage

// File: hdl/occupancy_light_controller_unit.sv
// Top level of the occupancy light controller.
//
//   channel  direction  handshake          beat payload
//   in       in         in_valid/in_stall  olc_pkg::in_t  (one poll)
//   out      out        out_valid/out_stall olc_pkg::out_t (lamp commands)
//   cfg      in         cfg_write          cfg_index, cfg_data
//
// One poll is accepted per cycle while in_stall is low; its commands, if any, pass
// through the poll register, then the result register, into a 4-entry buffer.
// The sample/expiry update of the controller state is combinational and feeds the state registers.
// in_stall rises only when the result buffer holds two beats or more.
// Reset (synchronous, active high) clears state, registers and the buffer.
`timescale 1ns / 1ps

module occupancy_light_controller_unit #(
  parameter longint unsigned SAMPLE_PERIOD_US = olc_pkg::SAMPLE_PERIOD_US_DEF,
  parameter longint unsigned MANUAL_HOLD_US   = olc_pkg::MANUAL_HOLD_US_DEF,
  parameter longint unsigned VACANT_HOLD_US   = olc_pkg::VACANT_HOLD_US_DEF,
  parameter int              TIME_WIDTH       = olc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  olc_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output olc_pkg::out_t                       out_data,
  input  logic                                cfg_write,
  input  logic [olc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [olc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  olc_pkg::cfg_t cfg;
  logic          take;
  logic          result_valid;
  olc_pkg::out_t result;

  assign take = in_valid && !in_stall;

  olc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  olc_core #(
    .SAMPLE_PERIOD_US (SAMPLE_PERIOD_US),
    .MANUAL_HOLD_US   (MANUAL_HOLD_US),
    .VACANT_HOLD_US   (VACANT_HOLD_US),
    .TIME_WIDTH       (TIME_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (in_data),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  olc_out_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (result_valid),
    .push_data   (result),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .almost_full (in_stall)
  );

endmodule

// File: hdl/olc_cfg_regs.sv
// Configuration register file of the occupancy light controller.
`timescale 1ns / 1ps

module olc_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [olc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [olc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output olc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.night_mode       <= 1'b0;
      cfg.main_temperature <= olc_pkg::MAIN_TEMP_RST;
      cfg.back_color       <= '0;
      cfg.has_backlight    <= 1'b0;
      cfg.capability_mask  <= '0;
      cfg.lux_threshold    <= olc_pkg::LUX_THRESH_RST;
      cfg.dark_count_limit <= olc_pkg::DARK_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        olc_pkg::REG_NIGHT_MODE:       cfg.night_mode       <= cfg_data[0];
        olc_pkg::REG_MAIN_TEMPERATURE:
          cfg.main_temperature <= cfg_data[olc_pkg::TEMP_WIDTH-1:0];
        olc_pkg::REG_BACK_COLOR:
          cfg.back_color       <= cfg_data[olc_pkg::RGB_WIDTH-1:0];
        olc_pkg::REG_HAS_BACKLIGHT:    cfg.has_backlight    <= cfg_data[0];
        olc_pkg::REG_CAPABILITY_MASK:
          cfg.capability_mask  <= cfg_data[olc_pkg::CAP_WIDTH-1:0];
        olc_pkg::REG_LUX_THRESHOLD:
          cfg.lux_threshold    <= cfg_data[olc_pkg::LUX_WIDTH-1:0];
        olc_pkg::REG_DARK_COUNT_LIMIT:
          cfg.dark_count_limit <= cfg_data[olc_pkg::DARK_WIDTH-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

endmodule

// File: hdl/olc_core.sv
// Poll register, controller state and lamp command logic.
`timescale 1ns / 1ps

module olc_core #(
  parameter longint unsigned SAMPLE_PERIOD_US = olc_pkg::SAMPLE_PERIOD_US_DEF,
  parameter longint unsigned MANUAL_HOLD_US   = olc_pkg::MANUAL_HOLD_US_DEF,
  parameter longint unsigned VACANT_HOLD_US   = olc_pkg::VACANT_HOLD_US_DEF,
  parameter int              TIME_WIDTH       = olc_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  olc_pkg::in_t  item,
  input  olc_pkg::cfg_t cfg,
  output logic          result_valid,
  output olc_pkg::out_t result
);

  // Poll register
  logic         item_valid;
  olc_pkg::in_t item_q;

  // Controller state
  logic [TIME_WIDTH-1:0]              last_sample_time, last_sample_time_next;
  logic [TIME_WIDTH-1:0]              last_presence_time, last_presence_time_next;
  logic [TIME_WIDTH-1:0]              last_manual_time, last_manual_time_next;
  logic [olc_pkg::DARK_WIDTH-1:0]     dark_count, dark_count_next;
  logic                               manual_active, manual_active_next;
  logic                               light_enabled, light_enabled_next;
  logic [olc_pkg::LEVEL_WIDTH-1:0]    stored_level, stored_level_next;

  logic [TIME_WIDTH-1:0]              now;
  logic [TIME_WIDTH-1:0]              sample_diff, manual_diff, vacant_diff;
  logic                               sample_due, manual_expired, vacant_expired;
  logic [olc_pkg::LEVEL_WIDTH-1:0]    level_sat;
  logic                               changed;
  olc_pkg::out_t                      cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= take;
    end
    if (take) begin
      item_q <= item;
    end
  end

  assign now       = TIME_WIDTH'(item_q.now_us);
  assign level_sat = (item_q.lamp_level > olc_pkg::MAX_LEVEL) ? olc_pkg::MAX_LEVEL
                                                             : item_q.lamp_level;

  // Sample deadline: time running backwards never passes it
  assign sample_diff = now - last_sample_time;
  assign sample_due  = (now > last_sample_time) && (64'(sample_diff) > SAMPLE_PERIOD_US);

  // Expiry checks use the times as they stand after this poll's sample
  assign manual_diff    = now - last_manual_time_next;
  assign vacant_diff    = now - last_presence_time_next;
  assign manual_expired = (now > last_manual_time_next) &&
                          (64'(manual_diff) > MANUAL_HOLD_US);
  assign vacant_expired = (now > last_presence_time_next) &&
                          (64'(vacant_diff) > VACANT_HOLD_US);

  always_comb begin
    last_sample_time_next   = last_sample_time;
    last_presence_time_next = last_presence_time;
    last_manual_time_next   = last_manual_time;
    dark_count_next         = dark_count;
    manual_active_next      = manual_active;
    light_enabled_next      = light_enabled;
    stored_level_next       = stored_level;
    changed                 = 1'b0;

    if (sample_due) begin
      // Manual switching of the lamp starts manual mode
      if (item_q.lamp_on_valid && (light_enabled != item_q.lamp_on)) begin
        light_enabled_next    = item_q.lamp_on;
        manual_active_next    = 1'b1;
        last_manual_time_next = now;
        changed               = 1'b1;
      end
      if (!cfg.night_mode && item_q.lamp_level_valid && (stored_level != level_sat)) begin
        stored_level_next = level_sat;
        changed           = 1'b1;
      end
      if (item_q.presence_valid && item_q.presence) begin
        last_presence_time_next = now;
      end
      if (item_q.ambient_valid && (item_q.ambient_lux < cfg.lux_threshold)) begin
        if (dark_count != olc_pkg::DARK_MAX) begin
          dark_count_next = dark_count + 8'd1;
        end
      end else begin
        dark_count_next = '0;
      end
      if (!manual_active_next && item_q.presence_valid) begin
        if (item_q.presence && (dark_count_next > cfg.dark_count_limit)) begin
          if (!light_enabled_next) begin
            light_enabled_next = 1'b1;
            manual_active_next = 1'b0;
            changed            = 1'b1;
          end
        end else if (!item_q.presence) begin
          if (light_enabled_next) begin
            light_enabled_next = 1'b0;
            manual_active_next = 1'b0;
            changed            = 1'b1;
          end
        end
      end
      last_sample_time_next = now;
    end

    if (manual_active_next && ((light_enabled_next && manual_expired) ||
                               (!light_enabled_next && vacant_expired))) begin
      manual_active_next = 1'b0;
    end
  end

  // Lamp commands from the final state; unwritten fields stay zero
  always_comb begin
    cmd = '0;
    if (cfg.night_mode) begin
      if (cfg.has_backlight) begin
        if (cfg.capability_mask[olc_pkg::CAP_BACK_COLOUR]) begin
          cmd.back_color_cmd   = olc_pkg::RED_RGB;
          cmd.back_color_write = 1'b1;
        end
        if (cfg.capability_mask[olc_pkg::CAP_BACK_LEVEL]) begin
          cmd.back_level_cmd   = olc_pkg::NIGHT_BACK_LEVEL;
          cmd.back_level_write = 1'b1;
        end
      end else begin
        cmd.main_red_write = cfg.capability_mask[olc_pkg::CAP_MAIN_COLOUR];
        if (cfg.capability_mask[olc_pkg::CAP_MAIN_TEMP]) begin
          cmd.main_temp_cmd   = olc_pkg::NIGHT_TEMP;
          cmd.main_temp_write = 1'b1;
        end
        if (cfg.capability_mask[olc_pkg::CAP_MAIN_LEVEL]) begin
          cmd.main_level_cmd   = olc_pkg::NIGHT_MAIN_LEVEL;
          cmd.main_level_write = 1'b1;
        end
      end
    end else begin
      if (cfg.capability_mask[olc_pkg::CAP_MAIN_TEMP]) begin
        cmd.main_temp_cmd   = cfg.main_temperature;
        cmd.main_temp_write = 1'b1;
      end
      if (cfg.capability_mask[olc_pkg::CAP_MAIN_LEVEL]) begin
        cmd.main_level_cmd   = stored_level_next;
        cmd.main_level_write = 1'b1;
      end
      if (cfg.has_backlight) begin
        if (cfg.capability_mask[olc_pkg::CAP_BACK_COLOUR]) begin
          cmd.back_color_cmd   = cfg.back_color;
          cmd.back_color_write = 1'b1;
        end
        if (cfg.capability_mask[olc_pkg::CAP_BACK_LEVEL]) begin
          cmd.back_level_cmd   = stored_level_next;
          cmd.back_level_write = 1'b1;
        end
      end
    end
    if (cfg.has_backlight) begin
      cmd.main_on_cmd = !cfg.night_mode && light_enabled_next;
      cmd.back_on_cmd = light_enabled_next;
    end else begin
      cmd.main_on_cmd = light_enabled_next;
      cmd.back_on_cmd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample_time   <= '0;
      last_presence_time <= '0;
      last_manual_time   <= '0;
      dark_count         <= '0;
      manual_active      <= 1'b0;
      light_enabled      <= 1'b0;
      stored_level       <= '0;
      result_valid       <= 1'b0;
    end else begin
      result_valid <= item_valid && changed;
      if (item_valid) begin
        last_sample_time   <= last_sample_time_next;
        last_presence_time <= last_presence_time_next;
        last_manual_time   <= last_manual_time_next;
        dark_count         <= dark_count_next;
        manual_active      <= manual_active_next;
        light_enabled      <= light_enabled_next;
        stored_level       <= stored_level_next;
      end
    end
    if (item_valid && changed) begin
      result <= cmd;
    end
  end

endmodule

// File: hdl/olc_out_fifo.sv
// Result buffer of the occupancy light controller.
`timescale 1ns / 1ps

module olc_out_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  olc_pkg::out_t push_data,
  input  logic          out_stall,
  output logic          out_valid,
  output olc_pkg::out_t out_data,
  output logic          almost_full
);

  olc_pkg::out_t                        mem [olc_pkg::OUT_DEPTH];
  logic [olc_pkg::OUT_PTR_WIDTH-1:0]    wr_ptr;
  logic [olc_pkg::OUT_PTR_WIDTH-1:0]    rd_ptr;
  logic [olc_pkg::OUT_CNT_WIDTH-1:0]    count, count_next;
  logic                                 pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  // Two beats may still be on their way from the poll register and core,
  // and a third is taken at the same edge: keep room for all three
  assign almost_full = (count >= olc_pkg::OUT_CNT_WIDTH'(olc_pkg::OUT_DEPTH - 2));

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/olc_checker.sv
// Port-level checks of the occupancy light controller and their binding.
`timescale 1ns / 1ps

module olc_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input olc_pkg::out_t out_data
);

  // Buffer is empty once reset has been applied
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat shown straight after reset");

  // A held beat keeps its commands
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  a_main_level_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.main_level_write) |-> (out_data.main_level_cmd == '0))
    else $error("unwritten main level is not zero");

  a_back_colour_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.back_color_write) |-> (out_data.back_color_cmd == '0))
    else $error("unwritten back colour is not zero");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.main_level_cmd <= olc_pkg::MAX_LEVEL) &&
                   (out_data.back_level_cmd <= olc_pkg::MAX_LEVEL)))
    else $error("brightness command above full scale");

endmodule

bind occupancy_light_controller_unit olc_checker u_olc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: dv/occupancy_light_controller_unit_test.sv
// Self-checking testbench for the occupancy light controller unit.
`timescale 1ns / 1ps

module occupancy_light_controller_unit_test;
  import olc_pkg::*;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;  // no register here
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned PHASE_POLLS = 150;
  localparam longint unsigned SP = SAMPLE_PERIOD_US_DEF;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  // controller model
  cfg_t regs_model;
  longint unsigned seen_sample_us;
  longint unsigned seen_presence_us;
  longint unsigned manual_start_us;
  logic [DARK_WIDTH-1:0] dark_run;
  bit manual_hold;
  bit lamp_enabled;
  logic [LEVEL_WIDTH-1:0] lamp_level_kept;

  out_t cmd_q[$];
  out_t cmd_head;
  longint unsigned t_now;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit src_gaps;
  bit sink_stalls;
  bit hold_req;

  occupancy_light_controller_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void power_on_controller();
    regs_model = '0;
    regs_model.main_temperature = MAIN_TEMP_RST;
    regs_model.lux_threshold = LUX_THRESH_RST;
    regs_model.dark_count_limit = DARK_LIMIT_RST;
    seen_sample_us = 0;
    seen_presence_us = 0;
    manual_start_us = 0;
    dark_run = '0;
    manual_hold = 1'b0;
    lamp_enabled = 1'b0;
    lamp_level_kept = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                                    logic [CFG_DATA_WIDTH-1:0] d);
    unique case (idx)
      REG_NIGHT_MODE:       regs_model.night_mode = d[0];
      REG_MAIN_TEMPERATURE: regs_model.main_temperature = d[TEMP_WIDTH-1:0];
      REG_BACK_COLOR:       regs_model.back_color = d[RGB_WIDTH-1:0];
      REG_HAS_BACKLIGHT:    regs_model.has_backlight = d[0];
      REG_CAPABILITY_MASK:  regs_model.capability_mask = d[CAP_WIDTH-1:0];
      REG_LUX_THRESHOLD:    regs_model.lux_threshold = d[LUX_WIDTH-1:0];
      REG_DARK_COUNT_LIMIT: regs_model.dark_count_limit = d[DARK_WIDTH-1:0];
      default: ;
    endcase
  endfunction

  // "last + hold < now" without any sum that could wrap
  function automatic bit past_deadline(longint unsigned stamp, longint unsigned last,
                                       longint unsigned hold);
    return stamp > last && (stamp - last) > hold;
  endfunction

  function automatic bit switch_lamp(bit en, bit by_hand, longint unsigned stamp);
    if (lamp_enabled == en) return 1'b0;
    lamp_enabled = en;
    manual_hold = by_hand;
    if (by_hand) manual_start_us = stamp;
    return 1'b1;
  endfunction

  function automatic out_t lamp_commands();
    out_t o;
    logic [CAP_WIDTH-1:0] cap;
    o = '0;
    cap = regs_model.capability_mask;
    if (regs_model.night_mode) begin
      if (regs_model.has_backlight) begin
        if (cap[CAP_BACK_COLOUR]) begin
          o.back_color_cmd = RED_RGB;
          o.back_color_write = 1'b1;
        end
        if (cap[CAP_BACK_LEVEL]) begin
          o.back_level_cmd = NIGHT_BACK_LEVEL;
          o.back_level_write = 1'b1;
        end
      end else begin
        if (cap[CAP_MAIN_COLOUR]) o.main_red_write = 1'b1;
        if (cap[CAP_MAIN_TEMP]) begin
          o.main_temp_cmd = NIGHT_TEMP;
          o.main_temp_write = 1'b1;
        end
        if (cap[CAP_MAIN_LEVEL]) begin
          o.main_level_cmd = NIGHT_MAIN_LEVEL;
          o.main_level_write = 1'b1;
        end
      end
    end else begin
      if (cap[CAP_MAIN_TEMP]) begin
        o.main_temp_cmd = regs_model.main_temperature;
        o.main_temp_write = 1'b1;
      end
      if (cap[CAP_MAIN_LEVEL]) begin
        o.main_level_cmd = lamp_level_kept;
        o.main_level_write = 1'b1;
      end
      if (regs_model.has_backlight) begin
        if (cap[CAP_BACK_COLOUR]) begin
          o.back_color_cmd = regs_model.back_color;
          o.back_color_write = 1'b1;
        end
        if (cap[CAP_BACK_LEVEL]) begin
          o.back_level_cmd = lamp_level_kept;
          o.back_level_write = 1'b1;
        end
      end
    end
    if (regs_model.has_backlight) begin
      o.main_on_cmd = regs_model.night_mode ? 1'b0 : lamp_enabled;
      o.back_on_cmd = lamp_enabled;
    end else begin
      o.main_on_cmd = lamp_enabled;
      o.back_on_cmd = 1'b0;
    end
    return o;
  endfunction

  // One poll through the controller; returns 1 when the lamps are updated.
  function automatic bit advance_controller(in_t p, output out_t cmds);
    longint unsigned stamp;
    logic [LEVEL_WIDTH-1:0] lvl;
    bit changed;
    stamp = p.now_us;
    lvl = (p.lamp_level > MAX_LEVEL) ? MAX_LEVEL : p.lamp_level;
    changed = 1'b0;
    cmds = '0;
    if (past_deadline(stamp, seen_sample_us, SP)) begin
      if (p.lamp_on_valid && lamp_enabled != p.lamp_on)
        changed |= switch_lamp(p.lamp_on, 1'b1, stamp);
      if (!regs_model.night_mode && p.lamp_level_valid && lamp_level_kept != lvl) begin
        lamp_level_kept = lvl;
        changed = 1'b1;
      end
      if (p.presence_valid && p.presence) seen_presence_us = stamp;
      if (p.ambient_valid && p.ambient_lux < regs_model.lux_threshold) begin
        if (dark_run != DARK_MAX) dark_run++;
      end else begin
        dark_run = '0;
      end
      if (!manual_hold && p.presence_valid) begin
        if (p.presence && dark_run > regs_model.dark_count_limit)
          changed |= switch_lamp(1'b1, 1'b0, stamp);
        else if (!p.presence)
          changed |= switch_lamp(1'b0, 1'b0, stamp);
      end
      seen_sample_us = stamp;
    end
    if (manual_hold &&
        ((lamp_enabled && past_deadline(stamp, manual_start_us, MANUAL_HOLD_US_DEF)) ||
         (!lamp_enabled && past_deadline(stamp, seen_presence_us, VACANT_HOLD_US_DEF))))
      manual_hold = 1'b0;
    if (changed) cmds = lamp_commands();
    return changed;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (cmd_q.size() == 0) begin
        report_mismatch("beat with nothing pending", out_data, '0);
      end else begin
        cmd_head = cmd_q.pop_front();
        check_field("main_on_cmd", out_data.main_on_cmd, cmd_head.main_on_cmd);
        check_field("back_on_cmd", out_data.back_on_cmd, cmd_head.back_on_cmd);
        check_field("main_level_cmd", out_data.main_level_cmd, cmd_head.main_level_cmd);
        check_field("main_level_write", out_data.main_level_write,
                    cmd_head.main_level_write);
        check_field("main_temp_cmd", out_data.main_temp_cmd, cmd_head.main_temp_cmd);
        check_field("main_temp_write", out_data.main_temp_write, cmd_head.main_temp_write);
        check_field("main_red_write", out_data.main_red_write, cmd_head.main_red_write);
        check_field("back_color_cmd", out_data.back_color_cmd, cmd_head.back_color_cmd);
        check_field("back_color_write", out_data.back_color_write,
                    cmd_head.back_color_write);
        check_field("back_level_cmd", out_data.back_level_cmd, cmd_head.back_level_cmd);
        check_field("back_level_write", out_data.back_level_write,
                    cmd_head.back_level_write);
      end
    end
  end

  // watchdog: give up when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, or one long hold-off on request
  initial begin
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        len = HOLD_CYCLES;
      end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
        len = pick_gap();
      end else begin
        len = 0;
      end
      @(negedge clk);
      out_stall <= (len != 0);
      if (len > 1) repeat (len - 1) @(negedge clk);
    end
  end

  task automatic send_poll(in_t p);
    out_t cmds;
    int unsigned gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_controller(p, cmds)) cmd_q.push_back(cmds);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      @(negedge clk);
      in_valid <= 1'b0;
      if (gap > 1) repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
    cfg_write <= 1'b0;
    apply_reg(idx, d);
  endtask

  task automatic load_config(logic [23:0] night, logic [23:0] temp, logic [23:0] back,
                             logic [23:0] has_back, logic [23:0] cap, logic [23:0] lux,
                             logic [23:0] limit);
    write_reg(REG_NIGHT_MODE, night);
    write_reg(REG_MAIN_TEMPERATURE, temp);
    write_reg(REG_BACK_COLOR, back);
    write_reg(REG_HAS_BACKLIGHT, has_back);
    write_reg(REG_CAPABILITY_MASK, cap);
    write_reg(REG_LUX_THRESHOLD, lux);
    write_reg(REG_DARK_COUNT_LIMIT, limit);
  endtask

  // drop valid, drain every pending beat, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic in_t poll_of(longint unsigned stamp, bit on, bit on_ok,
                                  logic [LEVEL_WIDTH-1:0] lvl, bit lvl_ok, bit pres,
                                  bit pres_ok, logic [LUX_WIDTH-1:0] lux, bit lux_ok);
    in_t p;
    p.now_us = stamp[NOW_WIDTH-1:0];
    p.lamp_on = on;
    p.lamp_on_valid = on_ok;
    p.lamp_level = lvl;
    p.lamp_level_valid = lvl_ok;
    p.presence = pres;
    p.presence_valid = pres_ok;
    p.ambient_lux = lux;
    p.ambient_valid = lux_ok;
    return p;
  endfunction

  function automatic void step_time();
    t_now += SP + 1 + $urandom_range(0, 50000);
  endfunction

  // a sample that flips the lamp by hand, so it always yields a beat
  task automatic send_toggle();
    step_time();
    send_poll(poll_of(t_now, !lamp_enabled, 1'b1, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0));
  endtask

  function automatic in_t next_poll();
    in_t p;
    int unsigned r;
    longint unsigned stamp;
    bit noise;
    logic [LUX_WIDTH-1:0] thr;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      t_now += SP + 1 + $urandom_range(0, 200000);
      stamp = t_now;
    end else if (r < 85) begin
      t_now += $urandom_range(0, SP);
      stamp = t_now;
    end else if (r < 92) begin
      t_now += MANUAL_HOLD_US_DEF + $urandom_range(0, 400000000);
      stamp = t_now;
    end else if (r < 96) begin
      stamp = t_now - $urandom_range(1, SP);  // running backwards
    end else begin
      t_now += SP + $urandom_range(0, 1);     // right on the window edge
      stamp = t_now;
    end
    noise = ($urandom_range(0, 9) == 0);
    thr = regs_model.lux_threshold;
    p.now_us = stamp[NOW_WIDTH-1:0];
    p.lamp_on = noise ? 1'($urandom_range(0, 1))
                      : (lamp_enabled ^ ($urandom_range(0, 9) == 0));
    p.lamp_on_valid = ($urandom_range(0, 9) != 0);
    p.lamp_level = (noise || $urandom_range(0, 4) == 0) ? LEVEL_WIDTH'($urandom_range(0, 127))
                                                         : lamp_level_kept;
    p.lamp_level_valid = ($urandom_range(0, 6) != 0);
    p.presence = ($urandom_range(0, 4) < 3);
    p.presence_valid = ($urandom_range(0, 6) != 0);
    if (noise)
      p.ambient_lux = LUX_WIDTH'($urandom_range(0, 65535));
    else if (thr != 0 && $urandom_range(0, 4) != 0)
      p.ambient_lux = LUX_WIDTH'($urandom_range(0, thr - 1));
    else
      p.ambient_lux = LUX_WIDTH'($urandom_range(thr, 65535));
    p.ambient_valid = ($urandom_range(0, 9) != 0);
    return p;
  endfunction

  function automatic logic [23:0] maybe_raw(logic [23:0] v);
    return ($urandom_range(0, 5) == 0) ? 24'($urandom()) : v;
  endfunction

  task automatic random_config();
    load_config(maybe_raw(24'($urandom_range(0, 1))),
                maybe_raw(24'($urandom_range(1000, 10000))),
                24'($urandom_range(0, 24'hffffff)),
                maybe_raw(24'($urandom_range(0, 1))),
                maybe_raw(24'($urandom_range(0, 31))),
                maybe_raw(($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 65535))
                                                       : 24'($urandom_range(0, 400))),
                maybe_raw(($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 255))
                                                       : 24'($urandom_range(0, 10))));
  endtask

  task automatic test_sample_window();
    send_poll(poll_of(0, 1, 1, 0, 1, 0, 1, 0, 1));                // time zero never samples
    send_poll(poll_of(SP, 1, 1, 0, 1, 0, 1, 0, 1));               // exactly one period
    send_poll(poll_of(SP + 1, 1, 1, 127, 1, 1, 1, 0, 1));         // manual on, level clamps
    send_poll(poll_of(2 * SP + 1, 0, 1, 3, 1, 0, 1, 0, 1));       // inside the window
    send_poll(poll_of(2 * SP + 2, 0, 0, 100, 1, 0, 0, 65535, 1));
    send_poll(poll_of(5, 0, 1, 0, 1, 0, 1, 0, 1));                // backwards
    send_poll(poll_of(3 * SP + 3, 0, 1, 0, 0, 0, 1, 149, 1));     // manual off
    t_now = 3 * SP + 3;
  endtask

  task automatic test_manual_hold();
    settle();
    load_config(0, 4000, 0, 0, 31, 150, 0);
    step_time();
    send_poll(poll_of(t_now, 1, 1, 50, 1, 0, 1, 10, 1));
    step_time();
    send_poll(poll_of(t_now, 1, 1, 50, 1, 0, 1, 10, 1));   // vacant but held by hand
    t_now += MANUAL_HOLD_US_DEF + 1;
    send_poll(poll_of(t_now, 1, 1, 50, 1, 0, 1, 10, 1));   // hold lapses after this sample
    step_time();
    send_poll(poll_of(t_now, 1, 1, 50, 1, 0, 1, 10, 1));   // automatic off
    step_time();
    send_poll(poll_of(t_now, 1, 1, 50, 1, 0, 1, 10, 1));   // on by hand again
    step_time();
    send_poll(poll_of(t_now, 0, 1, 50, 1, 1, 1, 10, 1));   // off by hand while present
    t_now += VACANT_HOLD_US_DEF + 1;
    send_poll(poll_of(t_now, 0, 1, 50, 1, 0, 1, 10, 1));   // vacancy ends the hold
    step_time();
    send_poll(poll_of(t_now, 0, 1, 50, 1, 1, 1, 10, 1));   // automatic on in the dark
  endtask

  task automatic test_lamp_outputs();
    for (int night = 0; night < 2; night++) begin
      for (int back = 0; back < 2; back++) begin
        settle();
        load_config(night, 6500, 24'h123456, back, 31, 150, 120);
        send_toggle();
      end
    end
    settle();
    write_reg(REG_SPARE, 24'hffffff);
    write_reg(REG_NIGHT_MODE, 24'hfffffe);
    write_reg(REG_CAPABILITY_MASK, 24'hffffea);
    send_toggle();
  endtask

  task automatic test_dark_saturation();
    settle();
    load_config(0, 2700, 24'h00ff00, 1, 31, 65535, 255);
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    // let any hand hold lapse, then go vacant
    t_now += VACANT_HOLD_US_DEF + MANUAL_HOLD_US_DEF + 2;
    send_poll(poll_of(t_now, lamp_enabled, 1, lamp_level_kept, 1, 0, 1, 0, 0));
    step_time();
    send_poll(poll_of(t_now, lamp_enabled, 1, lamp_level_kept, 1, 0, 1, 0, 0));
    repeat (270) begin
      step_time();
      send_poll(poll_of(t_now, lamp_enabled, 1, lamp_level_kept, 1, 1, 1, 0, 1));
    end
    settle();
    write_reg(REG_DARK_COUNT_LIMIT, 254);
    step_time();
    send_poll(poll_of(t_now, lamp_enabled, 1, lamp_level_kept, 1, 1, 1, 0, 1));
  endtask

  task automatic test_backpressure();
    settle();
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_req = 1'b1;
    wait (!hold_req);
    repeat (12) send_toggle();
    repeat (6) send_toggle();
    // pause the sender until every pending beat has come out
    settle();
    repeat (6) send_toggle();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph == 0)
        load_config(0, 1000, 0, 0, 0, 0, 0);
      else if (ph == 1)
        load_config(1, 10000, 24'hffffff, 1, 31, 65535, 255);
      else
        random_config();
      src_gaps = (ph % 3 != 0);
      sink_stalls = (ph % 3 != 0);
      repeat (PHASE_POLLS) send_poll(next_poll());
    end
  endtask

  task automatic test_clock_limit();
    settle();
    random_config();
    send_poll(poll_of(48'hffff_ffff_ffff, 1, 1, 127, 1, 1, 1, 65535, 1));
    send_poll(poll_of(48'hffff_ffff_ffff, 0, 1, 0, 1, 0, 1, 0, 1));
    send_poll(poll_of(0, 0, 1, 0, 1, 0, 1, 0, 1));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    t_now = 0;
    power_on_controller();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_sample_window();
    test_manual_hold();
    test_lamp_outputs();
    test_dark_saturation();
    test_backpressure();
    test_random_phases();
    test_clock_limit();
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
